### hdl/olidu_pkg.sv
// Shared types and constants for the ordered list core.
// No dependencies; used by olidu_cell and ordered_list_insert_delete_update_core.
package olidu_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [2:0] {
        FN_INSERT   = 3'd0,
        FN_DELETE   = 3'd1,
        FN_UPDATE   = 3'd2,
        FN_SCAN_FWD = 3'd3,
        FN_SCAN_BWD = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_IGNORED   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_HOLD    = 3'd0,
        CMD_INSERT  = 3'd1,
        CMD_DELETE  = 3'd2,
        CMD_UPDATE  = 3'd3,
        CMD_ROT_FWD = 3'd4,
        CMD_ROT_BWD = 3'd5
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t           cmd;
        logic [DATA_W-1:0]   data;      // insert value or update search key
        logic [DATA_W-1:0]   new_data;  // update replacement
    } cell_ctrl_t;

endpackage

### hdl/olidu_cell.sv
// One list slot: holds an entry and moves it to or from its neighbors.
// Depends on olidu_pkg.
module olidu_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                        clk,
    input  olidu_pkg::cell_ctrl_t       ctrl,
    input  logic [CW-1:0]               pos,
    input  logic [CW-1:0]               count,
    input  logic [olidu_pkg::DATA_W-1:0] left_val,
    input  logic [olidu_pkg::DATA_W-1:0] right_val,
    input  logic [olidu_pkg::DATA_W-1:0] wrap_val,
    input  logic                        match_in,
    output logic                        match_out,
    output logic [olidu_pkg::DATA_W-1:0] val
);

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

    logic [olidu_pkg::DATA_W-1:0] val_reg;
    logic [olidu_pkg::DATA_W-1:0] val_next;
    logic                         live;
    logic                         match_here;

    assign live       = IDX_C < count;
    assign match_here = live && !match_in && (val_reg == ctrl.data);
    assign match_out  = match_in || match_here;
    assign val        = val_reg;

    always_comb
    begin
        val_next = val_reg;
        case (ctrl.cmd)
            olidu_pkg::CMD_INSERT:
            begin
                if (IDX_C > pos)
                    val_next = left_val;
                else if (IDX_C == pos)
                    val_next = ctrl.data;
            end
            olidu_pkg::CMD_DELETE:
            begin
                if (IDX_C >= pos)
                    val_next = right_val;
            end
            olidu_pkg::CMD_UPDATE:
            begin
                if (match_here)
                    val_next = ctrl.new_data;
            end
            olidu_pkg::CMD_ROT_FWD:
            begin
                // head wraps around to the tail slot
                if (IDX_P1 == count)
                    val_next = wrap_val;
                else if (IDX_P1 < count)
                    val_next = right_val;
            end
            olidu_pkg::CMD_ROT_BWD:
            begin
                // tail wraps around to the head slot
                if (IDX == 0)
                    val_next = wrap_val;
                else if (live)
                    val_next = left_val;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

### hdl/ordered_list_insert_delete_update_core.sv
// Bounded ordered list built as a chain of shifting slots.
// Insert, delete, update, unknown codes: one item per cycle, result registered the cycle
// after the transfer. Scans: the transfer arms the scan, then one slot of rotation and
// one element per cycle to the last; no new item till then. Both rates need rsp_stall low.
// Reset clears the entry count, scan state and output valid; slot contents are undefined.
// Depends on olidu_pkg and olidu_cell.
module ordered_list_insert_delete_update_core #(
    parameter int CAPACITY = olidu_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [2:0]                    func,
    input  logic [olidu_pkg::POS_W-1:0]   position,
    input  logic signed [olidu_pkg::DATA_W-1:0] value,
    input  logic signed [olidu_pkg::DATA_W-1:0] new_value,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [1:0]                    status,
    output logic                          has_element,
    output logic signed [olidu_pkg::DATA_W-1:0] element_out,
    output logic                          last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DW = olidu_pkg::DATA_W;

    logic [CW-1:0]            count_reg, count_next;
    logic                     scan_busy_reg, scan_busy_next;
    logic                     scan_fwd_reg, scan_fwd_next;
    logic [CW-1:0]            scan_left_reg, scan_left_next;

    logic                     out_valid_reg, out_valid_next;
    olidu_pkg::status_t       out_status_reg, out_status_next;
    logic                     out_has_reg, out_has_next;
    logic [DW-1:0]            out_elem_reg, out_elem_next;
    logic                     out_last_reg, out_last_next;

    olidu_pkg::cell_ctrl_t    ctrl;
    logic [CW-1:0]            pos_c;
    logic [CW-1:0]            cnt_m1;
    logic [DW-1:0]            tail_val;
    logic [DW-1:0]            wrap_val;
    logic                     out_free;
    logic                     req_fire;

    logic [DW-1:0]            cell_val [CAPACITY];
    logic [CAPACITY:0]        match_chain;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = scan_busy_reg || !out_free;
    assign req_fire  = req_valid && !req_stall;

    // clamp insert position to the append slot
    assign pos_c = (position >= olidu_pkg::POS_W'(count_reg)) ? count_reg
                                                                : position[CW-1:0];
    assign cnt_m1   = count_reg - 1'b1;
    assign tail_val = cell_val[cnt_m1[IW-1:0]];
    assign wrap_val = scan_fwd_reg ? cell_val[0] : tail_val;

    assign match_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DW-1:0] lv;
            logic [DW-1:0] rv;
            if (gi == 0)
            begin : g_head
                assign lv = '0;
            end
            else
            begin : g_mid_l
                assign lv = cell_val[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_tail
                assign rv = '0;
            end
            else
            begin : g_mid_r
                assign rv = cell_val[gi+1];
            end
            olidu_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .pos       (pos_c),
                .count     (count_reg),
                .left_val  (lv),
                .right_val (rv),
                .wrap_val  (wrap_val),
                .match_in  (match_chain[gi]),
                .match_out (match_chain[gi+1]),
                .val       (cell_val[gi])
            );
        end
    endgenerate

    always_comb
    begin
        ctrl.cmd        = olidu_pkg::CMD_HOLD;
        ctrl.data       = value;
        ctrl.new_data   = new_value;
        count_next      = count_reg;
        scan_busy_next  = scan_busy_reg;
        scan_fwd_next   = scan_fwd_reg;
        scan_left_next  = scan_left_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_status_next = out_status_reg;
        out_has_next    = out_has_reg;
        out_elem_next   = out_elem_reg;
        out_last_next   = out_last_reg;

        if (scan_busy_reg && out_free)
        begin
            // emit one element and rotate the chain by one slot
            ctrl.cmd        = scan_fwd_reg ? olidu_pkg::CMD_ROT_FWD : olidu_pkg::CMD_ROT_BWD;
            out_valid_next  = 1'b1;
            out_status_next = olidu_pkg::ST_DONE;
            out_has_next    = 1'b1;
            out_elem_next   = wrap_val;
            out_last_next   = (scan_left_reg == CW'(1));
            scan_left_next  = scan_left_reg - 1'b1;
            scan_busy_next  = (scan_left_reg != CW'(1));
        end
        else if (req_fire)
        begin
            out_valid_next  = 1'b1;
            out_has_next    = 1'b0;
            out_elem_next   = '0;
            out_last_next   = 1'b1;
            out_status_next = olidu_pkg::ST_IGNORED;
            case (olidu_pkg::func_t'(func))
                olidu_pkg::FN_INSERT:
                begin
                    if (count_reg == CW'(CAPACITY))
                        out_status_next = olidu_pkg::ST_FULL;
                    else
                    begin
                        ctrl.cmd        = olidu_pkg::CMD_INSERT;
                        count_next      = count_reg + 1'b1;
                        out_status_next = olidu_pkg::ST_DONE;
                    end
                end
                olidu_pkg::FN_DELETE:
                begin
                    if (position < olidu_pkg::POS_W'(count_reg))
                    begin
                        ctrl.cmd        = olidu_pkg::CMD_DELETE;
                        count_next      = cnt_m1;
                        out_status_next = olidu_pkg::ST_DONE;
                    end
                end
                olidu_pkg::FN_UPDATE:
                begin
                    ctrl.cmd        = olidu_pkg::CMD_UPDATE;
                    out_status_next = match_chain[CAPACITY] ? olidu_pkg::ST_DONE
                                                            : olidu_pkg::ST_NOT_FOUND;
                end
                olidu_pkg::FN_SCAN_FWD, olidu_pkg::FN_SCAN_BWD:
                begin
                    out_status_next = olidu_pkg::ST_DONE;
                    if (count_reg != '0)
                    begin
                        // hold the result slot; elements follow from the scan loop
                        out_valid_next = 1'b0;
                        scan_busy_next = 1'b1;
                        scan_fwd_next  = (olidu_pkg::func_t'(func) == olidu_pkg::FN_SCAN_FWD);
                        scan_left_next = count_reg;
                    end
                end
                default:
                begin
                    out_status_next = olidu_pkg::ST_IGNORED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_busy_reg <= 1'b0;
            scan_fwd_reg  <= 1'b0;
            scan_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            scan_busy_reg <= scan_busy_next;
            scan_fwd_reg  <= scan_fwd_next;
            scan_left_reg <= scan_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_has_reg    <= out_has_next;
        out_elem_reg   <= out_elem_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign has_element = out_has_reg;
    assign element_out = out_elem_reg;
    assign last        = out_last_reg;

endmodule
